// File: hw/rtl/sua_pkg.sv
// ----------------------------------------------------------------------------
// sua_pkg
// Shared widths, codes and token types for the service unit pool allocator.
// ----------------------------------------------------------------------------
package sua_pkg;

    localparam int TIME_W  = 32;  // now_time, 24.8
    localparam int DUR_W   = 24;  // service_time, 16.8
    localparam int UNTIL_W = 33;  // busy-until per unit
    localparam int IDLE_W  = 40;  // idle accumulator per unit
    localparam int TOT_W   = 44;  // pool totals
    localparam int IDX_W   = 3;   // reported unit index
    localparam int CFG_W   = 4;   // active_units register
    localparam int CNT_W   = 7;   // unit counts, covers the largest pool

    localparam logic [CFG_W-1:0] ACTIVE_RST = 4'd8;

    localparam logic REQ_ALLOC   = 1'b0;
    localparam logic REQ_ADVANCE = 1'b1;

    localparam logic [1:0] ST_GRANT = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_ZERO  = 2'd2;
    localparam logic [1:0] ST_ADV   = 2'd3;

    // request token, walks the cell row one cell per cycle
    typedef struct packed {
        logic               valid;
        logic               req_type;
        logic [TIME_W-1:0]  now;
        logic [DUR_W-1:0]   dur;
        logic               granted;
        logic [IDX_W-1:0]   index;
    } sua_req_t;

    // totals token, trails the request token through the cell row
    typedef struct packed {
        logic               valid;
        logic [TOT_W-1:0]   tidle;
        logic [TOT_W-1:0]   tbusy;
    } sua_sum_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [IDX_W-1:0]   index;
        logic [TOT_W-1:0]   tidle;
        logic [TOT_W-1:0]   tbusy;
    } sua_out_t;

    function automatic logic [TOT_W-1:0] sat_add_tot(input logic [TOT_W-1:0] a,
                                                     input logic [TOT_W-1:0] b);
        logic [TOT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TOT_W] ? {TOT_W{1'b1}} : s[TOT_W-1:0];
    endfunction

endpackage

// File: hw/rtl/sua_cell.sv
// ----------------------------------------------------------------------------
// sua_cell
// One service unit: holds its state, serves the passing request token and
// adds its share to the passing totals token.
// ----------------------------------------------------------------------------
module sua_cell #(
    parameter int CELL_ID = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              active,
    input  sua_pkg::sua_req_t req_in,
    output sua_pkg::sua_req_t req_out,
    input  sua_pkg::sua_sum_t sum_in,
    output sua_pkg::sua_sum_t sum_out
);
    import sua_pkg::*;

    logic                busy_reg, busy_next;
    logic [UNTIL_W-1:0]  until_reg, until_next;
    logic [IDLE_W-1:0]   idle_reg, idle_next;
    logic [UNTIL_W-1:0]  contrib_reg, contrib_next;
    sua_req_t            req_reg, req_next;
    sua_sum_t            sum_reg, sum_next;

    logic [UNTIL_W-1:0]  now_ext;
    logic [UNTIL_W:0]    gap;
    logic                before_now;
    logic [IDLE_W:0]     idle_sum;
    logic [IDLE_W-1:0]   idle_sat;
    logic                serve;
    logic                grant;
    logic                release_unit;

    assign now_ext    = {1'b0, req_in.now};
    // borrow of now - busy_until says busy_until lies after now
    assign gap        = {1'b0, now_ext} - {1'b0, until_reg};
    assign before_now = !gap[UNTIL_W] && (gap[UNTIL_W-1:0] != '0);
    assign idle_sum   = {1'b0, idle_reg} + {{(IDLE_W-UNTIL_W+1){1'b0}}, gap[UNTIL_W-1:0]};
    assign idle_sat   = idle_sum[IDLE_W] ? {IDLE_W{1'b1}} : idle_sum[IDLE_W-1:0];

    assign serve        = req_in.valid && active;
    assign grant        = serve && (req_in.req_type == REQ_ALLOC) && (req_in.dur != '0)
                          && !req_in.granted && (!busy_reg || !gap[UNTIL_W]);
    assign release_unit = serve && (req_in.req_type == REQ_ADVANCE) && before_now;

    always_comb
    begin
        busy_next  = busy_reg;
        until_next = until_reg;
        idle_next  = idle_reg;
        if (release_unit)
        begin
            idle_next  = idle_sat;
            until_next = now_ext;
            busy_next  = 1'b0;
        end
        else if (grant)
        begin
            if (before_now)
            begin
                idle_next = idle_sat;
            end
            busy_next  = 1'b1;
            until_next = now_ext + {{(UNTIL_W-DUR_W){1'b0}}, req_in.dur};
        end
    end

    // busy share from the settled state: busy_until minus idle, floored at zero
    always_comb
    begin
        if ({{(IDLE_W-UNTIL_W){1'b0}}, until_reg} > idle_reg)
        begin
            contrib_next = until_reg - idle_reg[UNTIL_W-1:0];
        end
        else
        begin
            contrib_next = '0;
        end
    end

    always_comb
    begin
        req_next = req_in;
        if (grant)
        begin
            req_next.granted = 1'b1;
            req_next.index   = IDX_W'(CELL_ID);
        end
    end

    always_comb
    begin
        sum_next = sum_in;
        if (sum_in.valid && active)
        begin
            sum_next.tidle = sat_add_tot(sum_in.tidle,
                                         {{(TOT_W-IDLE_W){1'b0}}, idle_reg});
            sum_next.tbusy = sat_add_tot(sum_in.tbusy,
                                         {{(TOT_W-UNTIL_W){1'b0}}, contrib_reg});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            until_reg   <= '0;
            idle_reg    <= '0;
            contrib_reg <= '0;
            req_reg     <= '0;
            sum_reg     <= '0;
        end
        else
        begin
            busy_reg    <= busy_next;
            until_reg   <= until_next;
            idle_reg    <= idle_next;
            contrib_reg <= contrib_next;
            req_reg     <= req_next;
            sum_reg     <= sum_next;
        end
    end

    assign req_out = req_reg;
    assign sum_out = sum_reg;

endmodule

// File: hw/rtl/sua_out_fifo.sv
// ----------------------------------------------------------------------------
// sua_out_fifo
// Two-entry result queue between the cell row and the output stream.
// ----------------------------------------------------------------------------
module sua_out_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  sua_pkg::sua_out_t push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output sua_pkg::sua_out_t pop_data,
    output logic [1:0]        count
);
    import sua_pkg::*;

    sua_out_t   mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign pop       = pop_valid && pop_ready;
    assign pop_valid = (count_reg != 2'd0);
    assign pop_data  = mem[rd_ptr_reg];
    assign count     = count_reg;

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: hw/rtl/service_unit_pool_allocator_top.sv
// ----------------------------------------------------------------------------
// service_unit_pool_allocator_top
// First-free allocator over a row of service unit cells with pool totals.
// ----------------------------------------------------------------------------
//  channel   dir  signals                         payload
//  s_axis    in   tvalid tready tdata tuser       request (now, duration, type)
//  m_axis    out  tvalid tready tdata tuser       result (index, totals, status)
//  cfg       in   valid ready data                active_units
//
//  A request token steps through one cell per cycle; a totals token follows
//  behind it, and a result is queued when the totals leave the row.
//  One request is in the cell row at a time: the next request is taken
//  once the result is queued and the result queue is not full.
//  Two-entry result queue; a new request is taken while one result waits.
//  Reset clears all unit state; active_units resets to 8.
// ----------------------------------------------------------------------------
module service_unit_pool_allocator_top #(
    parameter int UNITS = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [55:0]   s_axis_tdata,   // now_time[31:0], service_time[55:32]
    input  logic [0:0]    s_axis_tuser,   // req_type[0]
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [95:0]   m_axis_tdata,   // unit_index[2:0], total_idle[46:3],
                                          // total_busy[90:47], zero fill
    output logic [1:0]    m_axis_tuser,   // status[1:0]
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [3:0]    cfg_data        // active_units
);
    import sua_pkg::*;

    logic [CFG_W-1:0]  active_reg;
    logic [CNT_W-1:0]  act_cnt;
    logic              run_reg, run_next;
    sua_req_t          inj_reg;
    logic [1:0]        sum_dly_reg;
    logic [1:0]        fin_status_reg;
    logic [IDX_W-1:0]  fin_index_reg;
    logic [1:0]        q_count;
    logic              in_acc;
    logic              push;
    sua_out_t          push_data;
    sua_out_t          pop_data;
    sua_sum_t          sum_start;
    sua_req_t          last_req;

    sua_req_t          req_chain [UNITS+1];
    sua_sum_t          sum_chain [UNITS+1];
    logic [UNITS-1:0]  cell_active;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !run_reg && (q_count != 2'd2);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        if (active_reg == '0)
        begin
            act_cnt = CNT_W'(1);
        end
        else if ({{(CNT_W-CFG_W){1'b0}}, active_reg} > CNT_W'(UNITS))
        begin
            act_cnt = CNT_W'(UNITS);
        end
        else
        begin
            act_cnt = {{(CNT_W-CFG_W){1'b0}}, active_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= ACTIVE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            active_reg <= cfg_data;
        end
    end

    // request injection into the first cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inj_reg     <= '0;
            sum_dly_reg <= 2'b00;
            run_reg     <= 1'b0;
        end
        else
        begin
            inj_reg.valid <= in_acc;
            sum_dly_reg   <= {sum_dly_reg[0], inj_reg.valid};
            run_reg       <= run_next;
            if (in_acc)
            begin
                inj_reg.req_type <= s_axis_tuser[0];
                inj_reg.now      <= s_axis_tdata[31:0];
                inj_reg.dur      <= s_axis_tdata[55:32];
                inj_reg.granted  <= 1'b0;
                inj_reg.index    <= '0;
            end
        end
    end

    always_comb
    begin
        run_next = run_reg;
        if (in_acc)
        begin
            run_next = 1'b1;
        end
        else if (push)
        begin
            run_next = 1'b0;
        end
    end

    assign sum_start.valid = sum_dly_reg[1];
    assign sum_start.tidle = '0;
    assign sum_start.tbusy = '0;

    assign req_chain[0] = inj_reg;
    assign sum_chain[0] = sum_start;

    for (genvar k = 0; k < UNITS; k++)
    begin : g_cell
        assign cell_active[k] = (CNT_W'(k) < act_cnt);

        sua_cell #(
            .CELL_ID (k)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .active  (cell_active[k]),
            .req_in  (req_chain[k]),
            .req_out (req_chain[k+1]),
            .sum_in  (sum_chain[k]),
            .sum_out (sum_chain[k+1])
        );
    end

    // outcome leaves the row ahead of the totals; its status is held until they arrive
    assign last_req = req_chain[UNITS];

    always_ff @(posedge clk)
    begin
        if (last_req.valid)
        begin
            if (last_req.req_type == REQ_ADVANCE)
            begin
                fin_status_reg <= ST_ADV;
                fin_index_reg  <= '0;
            end
            else if (last_req.dur == '0)
            begin
                fin_status_reg <= ST_ZERO;
                fin_index_reg  <= '0;
            end
            else if (last_req.granted)
            begin
                fin_status_reg <= ST_GRANT;
                fin_index_reg  <= last_req.index;
            end
            else
            begin
                fin_status_reg <= ST_FULL;
                fin_index_reg  <= '0;
            end
        end
    end

    assign push             = sum_chain[UNITS].valid;
    assign push_data.status = fin_status_reg;
    assign push_data.index  = fin_index_reg;
    assign push_data.tidle  = sum_chain[UNITS].tidle;
    assign push_data.tbusy  = sum_chain[UNITS].tbusy;

    sua_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop_valid (m_axis_tvalid),
        .pop_ready (m_axis_tready),
        .pop_data  (pop_data),
        .count     (q_count)
    );

    assign m_axis_tuser = pop_data.status;
    assign m_axis_tdata = {5'd0, pop_data.tbusy, pop_data.tidle, pop_data.index};

    // totals follow the request token out of the row
    a_sum_follows_req: assert property (@(posedge clk) disable iff (!rst_n)
        last_req.valid |-> ##2 sum_chain[UNITS].valid)
        else $error("totals token lost behind request token");

    // a result is only produced for a request in flight
    a_push_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> run_reg)
        else $error("result without request in flight");

    // queue always has room when a result lands
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (q_count != 2'd2))
        else $error("result queue overflow");

    // the row is empty whenever a new request is taken
    a_row_empty: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |-> (!inj_reg.valid && sum_dly_reg == 2'b00 && !last_req.valid))
        else $error("request taken while row busy");

endmodule
